>>> hdl/ffcsa_pkg.sv
package ffcsa_pkg;

   // Map word geometry
   localparam int WORD_W    = 32;
   localparam int BIT_IDX_W = 5;

   // Field widths
   localparam int SLOT_W   = 12;
   localparam int BASE_W   = 11;
   localparam int WIDX_W   = SLOT_W - BIT_IDX_W;
   localparam int STATUS_W = 2;
   localparam int FLIP_W   = BIT_IDX_W + 1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd2;

   // Request actions
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic              action;
      logic [SLOT_W-1:0] run_length;
      logic [BASE_W-1:0] base_slot;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BASE_W-1:0]   granted_base;
      logic [SLOT_W-1:0]   used_slots;
   } rsp_type;

   // Per-word search controls and answer
   typedef struct packed {
      logic [SLOT_W-1:0]    carry;
      logic [SLOT_W-1:0]    len;
      logic                 is_last;
      logic [BIT_IDX_W-1:0] lim_bit;
   } scan_ctl_type;

   typedef struct packed {
      logic                 fit;
      logic [BIT_IDX_W-1:0] pos;
      logic [SLOT_W-1:0]    carry;
   } hit_type;

   // Per-word range update controls
   typedef struct packed {
      logic              alloc;
      logic [WIDX_W-1:0] widx;
      logic [SLOT_W-1:0] lo;
      logic [SLOT_W-1:0] hi;
   } upd_ctl_type;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_UPD_RD = 6'b001000,
      S_UPD_WR = 6'b010000,
      S_FINISH = 6'b100000
   } fsm_type;

endpackage

>>> hdl/ffcsa_if.sv
interface ffcsa_req_if;
   import ffcsa_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ffcsa_rsp_if;
   import ffcsa_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/ffcsa_ram.sv
module ffcsa_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ffcsa_search.sv
module ffcsa_search (
   input  logic [ffcsa_pkg::WORD_W-1:0] word,
   input  ffcsa_pkg::scan_ctl_type      ctl,
   output ffcsa_pkg::hit_type           hit
);
   import ffcsa_pkg::*;

   localparam int LEVELS = BIT_IDX_W;

   // Position of the highest used bit at or below each bit, plus one; zero if none
   logic [BIT_IDX_W:0] lv [LEVELS+1][WORD_W];
   logic [SLOT_W:0]    run [WORD_W];
   logic [WORD_W-1:0]  fit;

   // Mark used bits, treating slots past the heap end as used
   always_comb begin
      for (int p = 0; p < WORD_W; p++) begin
         if (word[p] || (ctl.is_last && (BIT_IDX_W'(p) > ctl.lim_bit))) begin
            lv[0][p] = (BIT_IDX_W+1)'(p + 1);
         end else begin
            lv[0][p] = '0;
         end
      end
      // Prefix scan: nearer used bit wins over a farther one
      for (int l = 0; l < LEVELS; l++) begin
         for (int p = 0; p < WORD_W; p++) begin
            lv[l+1][p] = lv[l][p];
            if (p >= (1 << l)) begin
               if (lv[l][p] == '0) begin
                  lv[l+1][p] = lv[l][p - (1 << l)];
               end
            end
         end
      end
   end

   // Free run length ending at each bit and the fit test
   always_comb begin
      for (int p = 0; p < WORD_W; p++) begin
         if (lv[LEVELS][p] == '0) begin
            run[p] = (SLOT_W+1)'(ctl.carry) + (SLOT_W+1)'(p + 1);
         end else begin
            run[p] = (SLOT_W+1)'(p + 1) - (SLOT_W+1)'(lv[LEVELS][p]);
         end
         fit[p] = (run[p] >= {1'b0, ctl.len});
      end
   end

   // Pick the lowest fitting bit
   always_comb begin
      hit.fit   = |fit;
      hit.pos   = '0;
      hit.carry = run[WORD_W-1][SLOT_W-1:0];
      for (int p = WORD_W - 1; p >= 0; p--) begin
         if (fit[p]) begin
            hit.pos = BIT_IDX_W'(p);
         end
      end
   end

endmodule

>>> hdl/ffcsa_update.sv
module ffcsa_update (
   input  logic [ffcsa_pkg::WORD_W-1:0] old_word,
   input  ffcsa_pkg::upd_ctl_type       ctl,
   output logic [ffcsa_pkg::WORD_W-1:0] new_word,
   output logic [ffcsa_pkg::FLIP_W-1:0] flips
);
   import ffcsa_pkg::*;

   logic [BIT_IDX_W-1:0] lo_bit;
   logic [BIT_IDX_W-1:0] hi_bit;
   logic [WORD_W-1:0]    mask;
   logic [WORD_W-1:0]    changed;

   // Bits of this word that fall in the slot range
   always_comb begin
      lo_bit = (ctl.widx == ctl.lo[SLOT_W-1:BIT_IDX_W]) ? ctl.lo[BIT_IDX_W-1:0] : '0;
      hi_bit = (ctl.widx == ctl.hi[SLOT_W-1:BIT_IDX_W]) ? ctl.hi[BIT_IDX_W-1:0] : '1;
      mask   = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (BIT_IDX_W'('1) - hi_bit));
   end

   // Flip only the bits that really change state, and count them
   always_comb begin
      changed  = ctl.alloc ? (mask & ~old_word) : (mask & old_word);
      new_word = old_word ^ changed;
      flips    = FLIP_W'($countones(changed));
   end

endmodule

>>> hdl/first_fit_contiguous_slot_allocator.sv
// Channel   Dir  Beat contents
// req_ch    in   action, run_length, base_slot
// rsp_ch    out  status, granted_base, used_slots
// csr       in   APB write of heap_capacity at byte address 0
//
// One request at a time. Allocate: the request is accepted, the first map read is primed, one
// map word is scanned per cycle (words of 32 slots, up to the word holding the last slot), each
// word marked is read and then written back, and the result is loaded. Free: the same read and write per word touched.
// The search is bound by the single read port of the map memory.
// After reset and after each capacity write a clearing pass zeroes each of the
// ceil(SLOT_COUNT/32) map words; no request is taken meanwhile.
// A result waits in an output register; the next request is taken while it stalls.
module first_fit_contiguous_slot_allocator #(
   parameter int SLOT_COUNT = 2048
) (
   input  logic        clock,
   input  logic        reset,
   ffcsa_req_if.sink   req_ch,
   ffcsa_rsp_if.source rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ffcsa_pkg::*;

   localparam int WORDS     = (SLOT_COUNT + WORD_W - 1) / WORD_W;
   localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CAP_LIMIT = (SLOT_COUNT < 4095) ? SLOT_COUNT : 4095;
   localparam logic [SLOT_W-1:0] CAP_MAX   = SLOT_W'(CAP_LIMIT);
   localparam logic [AW-1:0]     LAST_ADDR = AW'(WORDS - 1);

   fsm_type             state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [SLOT_W-1:0]   cap_ff, cap_in;
   logic [SLOT_W-1:0]   count_ff, count_in;
   logic                act_ff, act_in;
   logic [SLOT_W-1:0]   len_ff, len_in;
   logic [SLOT_W-1:0]   lo_ff, lo_in;
   logic [SLOT_W-1:0]   hi_ff, hi_in;
   logic [WIDX_W-1:0]   widx_ff, widx_in;
   logic [WIDX_W-1:0]   dwidx_ff, dwidx_in;
   logic                dvalid_ff, dvalid_in;
   logic [SLOT_W-1:0]   carry_ff, carry_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [BASE_W-1:0]   gbase_ff, gbase_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [WORD_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [WORD_W-1:0]   ram_rd_data;

   scan_ctl_type        scan_ctl;
   hit_type             hit;
   upd_ctl_type         upd_ctl;
   logic [WORD_W-1:0]   upd_word;
   logic [FLIP_W-1:0]   upd_flips;

   req_type             req;
   logic                accept;
   logic [SLOT_W:0]     free_end;
   logic [SLOT_W-1:0]   free_lo;
   logic [SLOT_W-1:0]   cap_m1;
   logic [SLOT_W-1:0]   hit_end;
   logic [SLOT_W-1:0]   hit_lo;
   logic                cfg_wr;
   logic [SLOT_W-1:0]   cfg_cap;

   // Occupancy map, one bit per slot
   ffcsa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS),
      .ADDR_W(AW)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // First-fit search over one map word
   assign cap_m1 = cap_ff - SLOT_W'(1);
   assign scan_ctl = '{
      carry:   carry_ff,
      len:     len_ff,
      is_last: (dwidx_ff == cap_m1[SLOT_W-1:BIT_IDX_W]),
      lim_bit: cap_m1[BIT_IDX_W-1:0]
   };

   ffcsa_search u_search (
      .word(ram_rd_data),
      .ctl (scan_ctl),
      .hit (hit)
   );

   // Set or clear a slot range within one map word
   assign upd_ctl = '{
      alloc: (act_ff == ACT_ALLOC),
      widx:  widx_ff,
      lo:    lo_ff,
      hi:    hi_ff
   };

   ffcsa_update u_update (
      .old_word(ram_rd_data),
      .ctl     (upd_ctl),
      .new_word(upd_word),
      .flips   (upd_flips)
   );

   // Request decode helpers
   assign req      = req_ch.payload;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept   = req_ch.valid && req_ch.ready;
   assign free_end = (SLOT_W+1)'(req.base_slot) + (SLOT_W+1)'(req.run_length);
   assign free_lo  = SLOT_W'(req.base_slot);
   assign hit_end  = {dwidx_ff, hit.pos};
   assign hit_lo   = hit_end + SLOT_W'(1) - len_ff;

   // Configuration port
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && !paddr[2];
   assign cfg_cap = (pwdata[SLOT_W-1:0] > CAP_MAX) ? CAP_MAX : pwdata[SLOT_W-1:0];
   assign prdata  = paddr[2] ? 32'd0 : 32'(cap_ff);

   // Result channel
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cap_in       = cap_ff;
      count_in     = count_ff;
      act_in       = act_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      widx_in      = widx_ff;
      dwidx_in     = dwidx_ff;
      dvalid_in    = dvalid_ff;
      carry_in     = carry_ff;
      status_in    = status_ff;
      gbase_in     = gbase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = AW'(widx_ff);
      ram_wr_data  = upd_word;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = AW'(widx_ff);

      // Drop a result beat once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in    = req.action;
               len_in    = req.run_length;
               gbase_in  = '0;
               dvalid_in = 1'b0;
               carry_in  = '0;
               widx_in   = '0;
               if (req.action == ACT_ALLOC) begin
                  if ((cap_ff == '0) || (req.run_length == '0) ||
                      (req.run_length > cap_ff)) begin
                     status_in = ST_INVALID;
                     state_in  = S_FINISH;
                  end else begin
                     status_in = ST_NO_SPACE;
                     state_in  = S_SCAN;
                  end
               end else begin
                  if ((cap_ff == '0) || (free_end > {1'b0, cap_ff})) begin
                     status_in = ST_INVALID;
                     state_in  = S_FINISH;
                  end else if (req.run_length == '0) begin
                     status_in = ST_DONE;
                     state_in  = S_FINISH;
                  end else begin
                     status_in = ST_DONE;
                     lo_in     = free_lo;
                     hi_in     = SLOT_W'(free_end - (SLOT_W+1)'(1));
                     widx_in   = free_lo[SLOT_W-1:BIT_IDX_W];
                     state_in  = S_UPD_RD;
                  end
               end
            end
         end
         S_SCAN: begin
            // Issue one word read per cycle, evaluate the word read last cycle
            ram_rd_en = 1'b1;
            widx_in   = widx_ff + WIDX_W'(1);
            dwidx_in  = widx_ff;
            dvalid_in = 1'b1;
            if (dvalid_ff) begin
               if (hit.fit) begin
                  status_in = ST_DONE;
                  lo_in     = hit_lo;
                  hi_in     = hit_end;
                  gbase_in  = hit_lo[BASE_W-1:0];
                  widx_in   = hit_lo[SLOT_W-1:BIT_IDX_W];
                  dvalid_in = 1'b0;
                  state_in  = S_UPD_RD;
               end else if (scan_ctl.is_last) begin
                  status_in = ST_NO_SPACE;
                  dvalid_in = 1'b0;
                  state_in  = S_FINISH;
               end else begin
                  carry_in = hit.carry;
               end
            end
         end
         S_UPD_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_UPD_WR;
         end
         S_UPD_WR: begin
            ram_wr_en = 1'b1;
            if (act_ff == ACT_ALLOC) begin
               count_in = count_ff + SLOT_W'(upd_flips);
            end else begin
               count_in = count_ff - SLOT_W'(upd_flips);
            end
            if (widx_ff == hi_ff[SLOT_W-1:BIT_IDX_W]) begin
               state_in = S_FINISH;
            end else begin
               widx_in  = widx_ff + WIDX_W'(1);
               state_in = S_UPD_RD;
            end
         end
         S_FINISH: begin
            // Load the result once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_data_in  = '{status: status_ff, granted_base: gbase_ff,
                                used_slots: count_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Capacity write restarts the map from empty
      if (cfg_wr) begin
         cap_in      = cfg_cap;
         count_in    = '0;
         clr_addr_in = '0;
         state_in    = S_CLEAR;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         cap_ff       <= '0;
         count_ff     <= '0;
         dvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         dvalid_ff    <= dvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload and working registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      len_ff      <= len_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      widx_ff     <= widx_in;
      dwidx_ff    <= dwidx_in;
      carry_ff    <= carry_in;
      status_ff   <= status_in;
      gbase_ff    <= gbase_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import ffcsa_pkg::*;

   localparam int SLOTS         = 2048;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 250;
   localparam int NUM_ROWS      = 26;
   localparam int RANDOM_PHASES = 6;

   localparam logic [2:0] CAP_REG_ADDR = 3'd0;

   // One line of the directed sequence: either a capacity write or a request
   typedef struct packed {
      logic        is_cfg;
      logic [11:0] cfg_value;
      req_type     item;
      logic        known;
      rsp_type     want;
   } step_row_type;

   typedef struct packed {
      int base;
      int len;
   } slot_run_type;

   // Known-answer rows: heap absent, small heap, clamped full heap, single slot
   localparam step_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      {1'b0, 12'd0,    ACT_ALLOC, 12'd1,    11'd0,    1'b1, ST_INVALID,  11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_FREE,  12'd0,    11'd0,    1'b1, ST_INVALID,  11'd0,    12'd0},
      {1'b1, 12'd64,   ACT_ALLOC, 12'd0,    11'd0,    1'b0, ST_DONE,     11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd0,    11'd0,    1'b1, ST_INVALID,  11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd65,   11'd0,    1'b1, ST_INVALID,  11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd64,   11'd0,    1'b1, ST_DONE,     11'd0,    12'd64},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd1,    11'd0,    1'b1, ST_NO_SPACE, 11'd0,    12'd64},
      {1'b0, 12'd0,    ACT_FREE,  12'd4,    11'd10,   1'b1, ST_DONE,     11'd0,    12'd60},
      {1'b0, 12'd0,    ACT_FREE,  12'd4,    11'd10,   1'b0, ST_DONE,     11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd5,    11'd0,    1'b1, ST_NO_SPACE, 11'd0,    12'd60},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd4,    11'd0,    1'b0, ST_DONE,     11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_FREE,  12'd5,    11'd60,   1'b1, ST_INVALID,  11'd0,    12'd64},
      {1'b0, 12'd0,    ACT_FREE,  12'd0,    11'd64,   1'b1, ST_DONE,     11'd0,    12'd64},
      {1'b0, 12'd0,    ACT_FREE,  12'd64,   11'd0,    1'b1, ST_DONE,     11'd0,    12'd0},
      {1'b1, 12'd4095, ACT_ALLOC, 12'd0,    11'd0,    1'b0, ST_DONE,     11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd2048, 11'd2047, 1'b0, ST_DONE,     11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_FREE,  12'd1,    11'd2047, 1'b1, ST_DONE,     11'd0,    12'd2047},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd1,    11'd0,    1'b1, ST_DONE,     11'd2047, 12'd2048},
      {1'b0, 12'd0,    ACT_FREE,  12'd2,    11'd2047, 1'b1, ST_INVALID,  11'd0,    12'd2048},
      {1'b0, 12'd0,    ACT_FREE,  12'd4095, 11'd0,    1'b1, ST_INVALID,  11'd0,    12'd2048},
      {1'b0, 12'd0,    ACT_FREE,  12'd2048, 11'd0,    1'b1, ST_DONE,     11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd4095, 11'd0,    1'b1, ST_INVALID,  11'd0,    12'd0},
      {1'b1, 12'd1,    ACT_ALLOC, 12'd0,    11'd0,    1'b0, ST_DONE,     11'd0,    12'd0},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd1,    11'd0,    1'b1, ST_DONE,     11'd0,    12'd1},
      {1'b0, 12'd0,    ACT_FREE,  12'd0,    11'd2047, 1'b1, ST_INVALID,  11'd0,    12'd1},
      {1'b0, 12'd0,    ACT_ALLOC, 12'd1,    11'd0,    1'b1, ST_NO_SPACE, 11'd0,    12'd1}
   };

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   ffcsa_req_if req_ch ();
   ffcsa_rsp_if rsp_ch ();

   first_fit_contiguous_slot_allocator #(.SLOT_COUNT(SLOTS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the heap: occupancy map, used count and capacity
   bit           slot_busy [SLOTS];
   int           busy_total = 0;
   int           heap_cap   = 0;
   slot_run_type live_runs [$];
   rsp_type      outstanding [$];

   int src_gap_pct    = 0;
   int sink_stall_pct = 0;
   int fail_count     = 0;
   int items_sent     = 0;
   int results_seen   = 0;
   int cap_writes     = 0;
   int done_seen      = 0;
   int invalid_seen   = 0;
   int full_seen      = 0;

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Apply one request to the shadow heap and return the answer it earns
   function automatic rsp_type predict_request(input req_type r);
      rsp_type res;
      int      run;
      int      start;
      int      b;
      int      l;
      res.status       = ST_DONE;
      res.granted_base = '0;
      b = int'(r.base_slot);
      l = int'(r.run_length);
      if (r.action == ACT_ALLOC) begin
         if (heap_cap == 0 || l == 0 || l > heap_cap) begin
            res.status = ST_INVALID;
         end else begin
            res.status = ST_NO_SPACE;
            run = 0;
            for (int i = 0; i < heap_cap; i++) begin
               run = slot_busy[i] ? 0 : run + 1;
               if (run == l) begin
                  start = i + 1 - l;
                  for (int j = start; j <= i; j++) slot_busy[j] = 1'b1;
                  busy_total += l;
                  res.status       = ST_DONE;
                  res.granted_base = start[BASE_W-1:0];
                  live_runs.insert(live_runs.size(), '{start, l});
                  break;
               end
            end
         end
      end else if (heap_cap == 0 || b + l > heap_cap) begin
         res.status = ST_INVALID;
      end else begin
         for (int j = b; j < b + l; j++) begin
            if (slot_busy[j]) begin
               slot_busy[j] = 1'b0;
               busy_total--;
            end
         end
      end
      res.used_slots = busy_total[SLOT_W-1:0];
      return res;
   endfunction

   // Mostly frees of runs handed out earlier and small allocations, plus noise
   function automatic req_type random_request();
      req_type      r;
      slot_run_type run;
      int           pick;
      int           idx;
      int           off;
      int           span;
      r.action     = ($urandom_range(99) < 55) ? ACT_ALLOC : ACT_FREE;
      r.base_slot  = BASE_W'($urandom_range(2047));
      r.run_length = SLOT_W'($urandom_range(4095));
      pick = int'($urandom_range(99));
      if (heap_cap == 0) return r;
      if (r.action == ACT_ALLOC) begin
         if (pick < 4) r.run_length = '0;
         else if (pick < 8) r.run_length = SLOT_W'($urandom_range(4095, heap_cap + 1));
         else if (pick < 14) r.run_length = SLOT_W'($urandom_range(heap_cap, 1));
         else r.run_length = SLOT_W'($urandom_range(heap_cap < 24 ? heap_cap : 24, 1));
      end else if (pick < 75 && live_runs.size() != 0) begin
         idx = int'($urandom_range(live_runs.size() - 1));
         run = live_runs[idx];
         live_runs.delete(idx);
         off  = 0;
         span = run.len;
         if ($urandom_range(3) == 0) begin
            off  = int'($urandom_range(run.len - 1));
            span = int'($urandom_range(run.len - off));
         end
         r.base_slot  = BASE_W'(run.base + off);
         r.run_length = SLOT_W'(span);
      end else if (pick < 88) begin
         off  = int'($urandom_range(heap_cap - 1));
         span = heap_cap - off;
         r.base_slot  = BASE_W'(off);
         r.run_length = SLOT_W'($urandom_range(span < 40 ? span : 40));
      end
      return r;
   endfunction

   // Hand one beat to the block, record the answer it should get, then maybe leave a gap
   task automatic issue_request(input req_type r, input logic known, input rsp_type want);
      rsp_type model_rsp;
      bit      lowered;
      req_ch.payload <= r;
      req_ch.valid   <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      model_rsp = predict_request(r);
      outstanding.insert(outstanding.size(), known ? want : model_rsp);
      items_sent++;
      lowered = 1'b0;
      while ($urandom_range(99) < src_gap_pct) begin
         if (!lowered) begin
            req_ch.valid <= 1'b0;
            lowered = 1'b1;
         end
         @(posedge clock);
      end
   endtask

   // Drain the block, then write the capacity over the register port
   task automatic program_capacity(input logic [11:0] value);
      req_ch.valid <= 1'b0;
      while (outstanding.size() != 0) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= CAP_REG_ADDR;
      pwdata  <= {20'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      heap_cap   = (int'(value) > SLOTS) ? SLOTS : int'(value);
      busy_total = 0;
      foreach (slot_busy[k]) slot_busy[k] = 1'b0;
      live_runs.delete();
      cap_writes++;
   endtask

   function automatic logic [11:0] pick_capacity(input int phase);
      case (phase)
         0: return 12'd2048;
         1: return 12'($urandom_range(64, 2));
         2: return 12'($urandom_range(4095, 2049));
         3: return 12'd0;
         4: return 12'($urandom_range(2047, 65));
         default: return 12'd1;
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [15:0] want_v,
                                  input logic [15:0] got_v);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
   endtask

   // Check each result beat against the oldest expectation, randomize ready
   always @(posedge clock) begin : rsp_check
      rsp_type got;
      rsp_type want;
      got = rsp_ch.payload;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         case (got.status)
            ST_DONE:     done_seen++;
            ST_INVALID:  invalid_seen++;
            ST_NO_SPACE: full_seen++;
            default:     ;
         endcase
         if (outstanding.size() == 0) begin
            fail_count++;
            $display("%0t: result beat with nothing pending, status %0d base %0d used %0d",
                     $time, got.status, got.granted_base, got.used_slots);
         end else begin
            want = outstanding.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 16'(want.status), 16'(got.status));
            if (got.granted_base !== want.granted_base)
               report_mismatch("granted_base", 16'(want.granted_base),
                               16'(got.granted_base));
            if (got.used_slots !== want.used_slots)
               report_mismatch("used_slots", 16'(want.used_slots), 16'(got.used_slots));
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   initial begin
      step_row_type row;
      int           count;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= CAP_REG_ADDR;
      pwdata         <= '0;
      src_gap_pct    = 23;
      sink_stall_pct = 69;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows
      for (int k = 0; k < NUM_ROWS; k++) begin
         row = DIRECTED_ROWS[k];
         if (row.is_cfg) program_capacity(row.cfg_value);
         else issue_request(row.item, row.known, row.want);
      end

      // Random phases under each handshake pattern
      for (int mode = 0; mode < 3; mode++) begin
         src_gap_pct    = (mode == 0) ? 23 : (mode == 1) ? 69 : 0;
         sink_stall_pct = (mode == 0) ? 69 : (mode == 1) ? 23 : 0;
         for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            program_capacity(pick_capacity(ph));
            count = (heap_cap == 0) ? 20 : 125;
            repeat (count) issue_request(random_request(), 1'b0, '0);
         end
      end

      // Let the last answers come back, then settle
      req_ch.valid <= 1'b0;
      while (outstanding.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests across %0d capacity writes and three handshake patterns.",
               items_sent, cap_writes);
      $display("Checked %0d results: %0d completed, %0d rejected, %0d with no free run.",
               results_seen, done_seen, invalid_seen, full_seen);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #50_000_000;
      $display("%0t: run did not complete in time", $time);
      $display("Some tests failed");
      $finish;
   end

endmodule

>>> filelist.f
hdl/ffcsa_pkg.sv
hdl/ffcsa_if.sv
hdl/ffcsa_ram.sv
hdl/ffcsa_search.sv
hdl/ffcsa_update.sv
hdl/first_fit_contiguous_slot_allocator.sv
test/tb.sv
